// ===== hw/rtl/sha_pkg.sv =====
`default_nettype none

package sha_pkg;

   localparam int QueueDepth = 16;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   localparam logic [5:0]  PadLimit = 6'd56;
   localparam logic [7:0]  PadByte  = 8'h80;
   localparam logic [63:0] ByteBits = 64'd8;

   // one message word on its way from the front to the compression core
   typedef struct packed {
      logic [31:0] word;
      logic        blk_end;   // word 15 of a block
      logic        last_blk;  // block that closes the message
   } sha_word_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] init_h(input logic [2:0] i);
      case (i)
         3'd0: init_h = 32'h6a09e667;
         3'd1: init_h = 32'hbb67ae85;
         3'd2: init_h = 32'h3c6ef372;
         3'd3: init_h = 32'ha54ff53a;
         3'd4: init_h = 32'h510e527f;
         3'd5: init_h = 32'h9b05688c;
         3'd6: init_h = 32'h1f83d9ab;
         default: init_h = 32'h5be0cd19;
      endcase
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      case (t)
         6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
         6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
         6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
         6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
         6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
         6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
         6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
         6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
         6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
         6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
         6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
         6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
         6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
         6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
         6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
         6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
         6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
         6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
         6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
         6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
         6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
         6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
         6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
         6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
         6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
         6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
         6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
         6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
         6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
         6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
         6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sha_req_if.sv =====
`default_nettype none

interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, output data_byte, output byte_present,
                   output end_of_message, input ready);
   modport sink (input valid, input data_byte, input byte_present,
                 input end_of_message, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sha_rsp_if.sv =====
`default_nettype none

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink (input valid, input digest_word, input word_index,
                 input last_word, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sha_front.sv =====
`default_nettype none

module sha_front (
   input  logic                  clock,
   input  logic                  reset,
   sha_req_if.sink               req_if,
   output logic                  q_push,
   output sha_pkg::sha_word_type q_wdata,
   input  logic                  q_full
);
   import sha_pkg::*;

   typedef enum logic {ACCEPT, PAD} state_type;

   state_type   state_ff, state_in;
   logic [31:0] word_ff, word_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic        first_ff, first_in;
   logic        len_blk_ff, len_blk_in;

   logic [1:0]  pos;
   logic [3:0]  widx;
   logic [5:0]  fill_nxt;
   logic [31:0] pad_first;
   logic        xfer;

   assign pos  = fill_ff[1:0];
   assign widx = fill_ff[5:2];
   assign req_if.ready = (state_ff == ACCEPT) && !q_full;
   assign xfer = req_if.valid && req_if.ready;

   // word holding the bytes gathered so far, then 0x80, then zeros
   always_comb begin
      case (pos)
         2'd0: pad_first = {PadByte, 24'h0};
         2'd1: pad_first = {word_ff[31:24], PadByte, 16'h0};
         2'd2: pad_first = {word_ff[31:16], PadByte, 8'h0};
         default: pad_first = {word_ff[31:8], PadByte};
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      word_in    = word_ff;
      fill_in    = fill_ff;
      bits_in    = bits_ff;
      first_in   = first_ff;
      len_blk_in = len_blk_ff;
      q_push     = 1'b0;
      q_wdata    = '0;
      fill_nxt   = fill_ff;
      case (state_ff)
         ACCEPT: begin
            if (xfer) begin
               if (req_if.byte_present) begin
                  case (pos)
                     2'd0: word_in[31:24] = req_if.data_byte;
                     2'd1: word_in[23:16] = req_if.data_byte;
                     2'd2: word_in[15:8]  = req_if.data_byte;
                     default: word_in[7:0] = req_if.data_byte;
                  endcase
                  fill_nxt = fill_ff + 6'd1;
                  bits_in  = bits_ff + ByteBits;
                  q_push   = (pos == 2'd3);
                  q_wdata.word     = word_in;
                  q_wdata.blk_end  = (widx == 4'd15);
                  q_wdata.last_blk = 1'b0;
               end
               fill_in = fill_nxt;
               if (req_if.end_of_message) begin
                  state_in   = PAD;
                  first_in   = 1'b1;
                  len_blk_in = (fill_nxt < PadLimit);
               end
            end
         end
         PAD: begin
            if (!q_full) begin
               q_push = 1'b1;
               if (first_ff) begin
                  q_wdata.word = pad_first;
               end else if (len_blk_ff && widx == 4'd14) begin
                  q_wdata.word = bits_ff[63:32];
               end else if (len_blk_ff && widx == 4'd15) begin
                  q_wdata.word = bits_ff[31:0];
               end else begin
                  q_wdata.word = '0;
               end
               q_wdata.blk_end  = (widx == 4'd15);
               q_wdata.last_blk = (widx == 4'd15) && len_blk_ff;
               first_in = 1'b0;
               fill_in  = {widx + 4'd1, 2'b00};
               if (widx == 4'd15) begin
                  if (len_blk_ff) begin
                     state_in = ACCEPT;
                     bits_in  = '0;
                  end else begin
                     len_blk_in = 1'b1;
                  end
               end
            end
         end
         default: state_in = ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ACCEPT;
         fill_ff    <= '0;
         bits_ff    <= '0;
         first_ff   <= 1'b0;
         len_blk_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         bits_ff    <= bits_in;
         first_ff   <= first_in;
         len_blk_ff <= len_blk_in;
      end
      word_ff <= word_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sha_queue.sv =====
`default_nettype none

module sha_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_push,
   input  sha_pkg::sha_word_type q_wdata,
   output logic                  q_full,
   input  logic                  q_pop,
   output sha_pkg::sha_word_type q_rdata,
   output logic                  q_avail
);
   import sha_pkg::*;

   sha_word_type         mem_ff [QueueDepth];
   logic [QueuePtrW-1:0] wptr_ff, wptr_in;
   logic [QueuePtrW-1:0] rptr_ff, rptr_in;
   logic [QueuePtrW:0]   count_ff, count_in;

   assign q_full  = (count_ff == (QueuePtrW+1)'(QueueDepth));
   assign q_avail = (count_ff != '0);
   assign q_rdata = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = q_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = q_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + (QueuePtrW+1)'(q_push) - (QueuePtrW+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (q_push) begin
         mem_ff[wptr_ff] <= q_wdata;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sha_back.sv =====
`default_nettype none

module sha_back (
   input  logic                  clock,
   input  logic                  reset,
   output logic                  q_pop,
   input  sha_pkg::sha_word_type q_rdata,
   input  logic                  q_avail,
   sha_rsp_if.source             rsp_if
);
   import sha_pkg::*;

   typedef enum logic [1:0] {RUN, FOLD, OUT} state_type;

   state_type   state_ff, state_in;
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] w_ff [16];   // w_ff[15] is w[t-1], w_ff[0] is w[t-16]
   logic [31:0] w_in [16];
   logic [5:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;
   logic        lastb_ff, lastb_in;

   logic        step;
   logic [31:0] sig0, sig1, wt, big0, big1, choose, major, t1, t2;

   always_comb begin
      sig0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      sig1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wt   = (round_ff[5:4] == 2'd0) ? q_rdata.word
                                     : sig1 + w_ff[9] + sig0 + w_ff[0];
      big1   = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      choose = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1     = v_ff[7] + big1 + choose + round_k(round_ff) + wt;
      big0   = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      major  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2     = big0 + major;
   end

   always_comb begin
      state_in = state_ff;
      v_in     = v_ff;
      chain_in = chain_ff;
      w_in     = w_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      lastb_in = lastb_ff;
      step     = 1'b0;
      q_pop    = 1'b0;
      case (state_ff)
         RUN: begin
            // the first 16 rounds take their word straight from the queue
            step  = (round_ff[5:4] != 2'd0) || q_avail;
            q_pop = step && (round_ff[5:4] == 2'd0);
            if (step) begin
               v_in[0] = t1 + t2;
               v_in[1] = v_ff[0];
               v_in[2] = v_ff[1];
               v_in[3] = v_ff[2];
               v_in[4] = v_ff[3] + t1;
               v_in[5] = v_ff[4];
               v_in[6] = v_ff[5];
               v_in[7] = v_ff[6];
               for (int i = 0; i < 15; i++) begin
                  w_in[i] = w_ff[i+1];
               end
               w_in[15] = wt;
               round_in = round_ff + 6'd1;
               if (round_ff == 6'd15) begin
                  lastb_in = q_rdata.last_blk;
               end
               if (round_ff == 6'd63) begin
                  state_in = FOLD;
               end
            end
         end
         FOLD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + v_ff[i];
               v_in[i]     = chain_ff[i] + v_ff[i];
            end
            idx_in   = '0;
            state_in = lastb_ff ? OUT : RUN;
         end
         OUT: begin
            if (rsp_if.ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) begin
                     chain_in[i] = init_h(3'(i));
                     v_in[i]     = init_h(3'(i));
                  end
                  state_in = RUN;
               end
            end
         end
         default: state_in = RUN;
      endcase
   end

   assign rsp_if.valid       = (state_ff == OUT);
   assign rsp_if.digest_word = chain_ff[idx_ff];
   assign rsp_if.word_index  = idx_ff;
   assign rsp_if.last_word   = (idx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RUN;
         round_ff <= '0;
         idx_ff   <= '0;
         lastb_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            v_ff[i]     <= init_h(3'(i));
            chain_ff[i] <= init_h(3'(i));
         end
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         lastb_ff <= lastb_in;
         v_ff     <= v_in;
         chain_ff <= chain_in;
      end
      w_ff <= w_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sha256_stream_hasher.sv =====
`default_nettype none

// channel  dir  handshake      payload
// req_if   in   valid/ready    data_byte[7:0], byte_present, end_of_message
// rsp_if   out  valid/ready    digest_word[31:0], word_index[2:0], last_word
//
// The front takes one byte per cycle unless the queue is full or it is padding,
// and packs words into a 16-word queue. Per 64-byte block the round core runs
// 16 rounds fed from the queue, 48 more and one fold, which sets the sustained
// rate near one byte/cycle. End of message: up to 18 padding words at one per
// cycle while the queue has room, input held off, final block, then 8 transfers.
// Synchronous reset loads the initial hash values; no clearing pass.
// A stalled result holds only the core; the front keeps filling the queue.

module sha256_stream_hasher (
   input  logic     clock,
   input  logic     reset,
   sha_req_if.sink  req_if,
   sha_rsp_if.source rsp_if
);
   import sha_pkg::*;

   logic         q_push;
   sha_word_type q_wdata;
   logic         q_full;
   logic         q_pop;
   sha_word_type q_rdata;
   logic         q_avail;

   sha_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_full  (q_full)
   );

   sha_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_rdata (q_rdata),
      .q_avail (q_avail)
   );

   sha_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_pop   (q_pop),
      .q_rdata (q_rdata),
      .q_avail (q_avail),
      .rsp_if  (rsp_if)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("word pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_avail)
      else $error("word popped from empty queue");

   a_digest_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && rsp_if.last_word) |=> !rsp_if.valid)
      else $error("digest output continued past last word");

endmodule

`default_nettype wire

// ===== tb/sha256_digest_checker.sv =====
`timescale 1ns / 1ps

module sha256_digest_checker (
   input  logic        clock,
   input  logic        reset,
   sha_req_if          req_mon,
   sha_rsp_if          rsp_mon,
   output int unsigned mismatches,
   output int unsigned words_due
);

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_beat_type;

   localparam logic [7:0]  PadMark   = 8'h80;
   localparam int unsigned BlockSize = 64;
   localparam int unsigned LenOffset = 56;

   localparam logic [31:0] HashInit [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] RoundConst [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   logic [31:0]     chain_h [8];
   logic [7:0]      blk [64];
   int unsigned     fill;
   logic [63:0]     bit_len;
   digest_beat_type digest_due [$];

   function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
      logic [63:0] doubled;
      doubled = {x, x} >> n;
      return doubled[31:0];
   endfunction

   task automatic load_initial();
      for (int k = 0; k < 8; k++) chain_h[k] = HashInit[k];
      fill    = 0;
      bit_len = '0;
   endtask

   task automatic fold_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int t = 0; t < 16; t++)
         w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      for (int t = 16; t < 64; t++)
         w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
                (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
      e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
      for (int t = 0; t < 64; t++) begin
         t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) +
              RoundConst[t] + w[t];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
   endtask

   task automatic absorb_item(input logic [7:0] data, input logic present, input logic eom);
      int unsigned     pos;
      digest_beat_type beat;
      if (present) begin
         blk[fill] = data;
         fill++;
         bit_len += 64'd8;
         if (fill == BlockSize) begin
            fold_block();
            fill = 0;
         end
      end
      if (eom) begin
         pos = fill;
         blk[pos] = PadMark;
         pos++;
         // no room for the length: pad out this block and start another
         if (pos > LenOffset) begin
            while (pos < BlockSize) begin
               blk[pos] = '0;
               pos++;
            end
            fold_block();
            pos = 0;
         end
         while (pos < LenOffset) begin
            blk[pos] = '0;
            pos++;
         end
         for (int k = 0; k < 8; k++) blk[LenOffset + k] = bit_len[63 - 8*k -: 8];
         fold_block();
         for (int k = 0; k < 8; k++) begin
            beat.word  = chain_h[k];
            beat.index = 3'(k);
            beat.last  = (k == 7);
            digest_due.push_back(beat);
         end
         load_initial();
      end
   endtask

   always @(posedge clock) begin
      digest_beat_type beat;
      if (reset) begin
         load_initial();
         digest_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (digest_due.size() == 0) begin
               $error("digest_word %h index %0d arrived with no digest pending",
                      rsp_mon.digest_word, rsp_mon.word_index);
               mismatches++;
            end else begin
               beat = digest_due.pop_front();
               if (rsp_mon.digest_word !== beat.word) begin
                  $error("digest_word: expected %h, got %h", beat.word, rsp_mon.digest_word);
                  mismatches++;
               end
               if (rsp_mon.word_index !== beat.index) begin
                  $error("word_index: expected %0d, got %0d", beat.index, rsp_mon.word_index);
                  mismatches++;
               end
               if (rsp_mon.last_word !== beat.last) begin
                  $error("last_word: expected %b, got %b", beat.last, rsp_mon.last_word);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            absorb_item(req_mon.data_byte, req_mon.byte_present, req_mon.end_of_message);
      end
      words_due <= digest_due.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned ItemTarget  = 370;
   localparam int unsigned HoldCycles  = 300;
   localparam int unsigned IdleLimit   = 2000;
   localparam int unsigned DrainCycles = 200;

   logic        clock;
   logic        reset = 1'b1;
   int unsigned mismatches;
   int unsigned words_due;
   int unsigned items_sent;
   int unsigned idle_cycles;
   bit          steady_send;
   bit          steady_recv;
   bit          hold_request;
   bit          holding;

   sha_req_if req_if();
   sha_rsp_if rsp_if();

   sha256_stream_hasher uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   sha256_digest_checker digest_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .mismatches (mismatches),
      .words_due  (words_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int unsigned pick_length();
      int unsigned pad_edges [6] = '{55, 56, 57, 63, 64, 65};
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 3) return $urandom_range(0, 8);
      if (r < 6) return pad_edges[$urandom_range(0, 5)];
      if (r < 9) return $urandom_range(9, 54);
      return $urandom_range(66, 130);
   endfunction

   task automatic send_item(input logic [7:0] data, input logic present, input logic eom);
      int unsigned gap;
      req_if.valid          <= 1'b1;
      req_if.data_byte      <= data;
      req_if.byte_present   <= present;
      req_if.end_of_message <= eom;
      do @(posedge clock); while (!req_if.ready);
      if (present || eom) items_sent++;
      gap = steady_send ? 0 : pick_gap();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_message(input int unsigned len, input bit end_on_byte);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   // extra edge first so the checker's count reflects the last transfer
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned stall;
      forever begin
         if (hold_request) begin
            rsp_if.ready <= 1'b0;
            holding = 1'b1;
            repeat (HoldCycles) @(posedge clock);
            hold_request = 1'b0;
            holding      = 1'b0;
         end else if (reset || steady_recv || $urandom_range(0, 99) < 65) begin
            rsp_if.ready <= !reset;
            @(posedge clock);
         end else begin
            stall = pick_gap();
            if (stall == 0) stall = 1;
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
         $display("sha256_stream_hasher: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_if.valid          <= 1'b0;
      req_if.data_byte      <= '0;
      req_if.byte_present   <= 1'b0;
      req_if.end_of_message <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty message, stray byte must be ignored
      send_item(8'hff, 1'b0, 1'b1);
      send_item(8'h3c, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'ha5, 1'b1, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      wait_drained();

      // digest held back while the sender keeps pushing until the input stalls
      hold_request = 1'b1;
      while (!holding) @(posedge clock);
      steady_send = 1'b1;
      send_message(3, 1'b1);
      send_message(120, 1'b1);
      steady_send = 1'b0;
      wait_drained();

      while (items_sent < ItemTarget) begin
         steady_send = ($urandom_range(0, 4) == 0);
         steady_recv = ($urandom_range(0, 4) == 0);
         send_message(pick_length(), 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 5) == 0) wait_drained();
      end

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0)
         $display("sha256_stream_hasher: match");
      else
         $display("sha256_stream_hasher: mismatch");
      $finish;
   end

endmodule

// ===== sha256_stream_hasher.f =====
hw/rtl/sha_pkg.sv
hw/rtl/sha_req_if.sv
hw/rtl/sha_rsp_if.sv
hw/rtl/sha_front.sv
hw/rtl/sha_queue.sv
hw/rtl/sha_back.sv
hw/rtl/sha256_stream_hasher.sv
tb/sha256_digest_checker.sv
tb/testbench.sv
